FILE: rtl/core/lru_sac_pkg.sv
package lru_sac_pkg;

    // Fixed field widths.
    localparam int STAMP_W = 32;
    localparam int TAG_W   = 64;
    localparam int ADDR_W  = 64;
    localparam int OP_W    = 2;
    localparam int OUT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [STAMP_W-1:0] SAT32 = '1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // Outcome codes of the first lookup.
    localparam logic [OUT_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUT_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUT_W-1:0] OUT_EVICT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [2:0] RST_SET_BITS    = 3'd4;
    localparam logic [5:0] RST_OFFSET_BITS = 6'd4;
    localparam logic [3:0] RST_WAYS        = 4'd1;

    // Outcome of one way selection.
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } t_pick;

    // Saturating increment of a 32-bit count.
    function automatic logic [STAMP_W-1:0] sat_inc(input logic [STAMP_W-1:0] v);
        sat_inc = (v == SAT32) ? v : v + 1'b1;
    endfunction

endpackage

FILE: rtl/core/lru_sac_ram.sv
module lru_sac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lru_sac_pick.sv
module lru_sac_pick #(
    parameter int MAX_WAYS = 8,
    localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int CW = $clog2(MAX_WAYS + 1)
) (
    input  logic [MAX_WAYS*lru_sac_pkg::STAMP_W-1:0] i_stamps,
    input  logic [MAX_WAYS*lru_sac_pkg::TAG_W-1:0]   i_tags,
    input  logic [lru_sac_pkg::TAG_W-1:0]            i_tag,
    input  logic [CW-1:0]                            i_ways,
    output lru_sac_pkg::t_pick                       o_res,
    output logic [WW-1:0]                            o_way
);

    localparam int P  = 1 << $clog2(MAX_WAYS);
    localparam int SW = lru_sac_pkg::STAMP_W;
    localparam int TW = lru_sac_pkg::TAG_W;

    always_comb begin
        logic [SW-1:0] st [MAX_WAYS];
        logic [TW-1:0] tg [MAX_WAYS];
        logic          en [MAX_WAYS];
        logic [SW-1:0] nst [2*P-1];
        logic [WW-1:0] nid [2*P-1];
        logic          hit;
        logic          empty;
        logic [WW-1:0] hway;
        logic [WW-1:0] eway;

        for (int w = 0; w < MAX_WAYS; w++) begin
            st[w] = i_stamps[w*SW +: SW];
            tg[w] = i_tags[w*TW +: TW];
            en[w] = (w < int'(i_ways));
        end

        // Lowest valid way whose tag matches.
        hit  = 1'b0;
        hway = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (en[w] && (st[w] != '0) && (tg[w] == i_tag)) begin
                hit  = 1'b1;
                hway = WW'(w);
            end
        end

        // Highest empty way.
        empty = 1'b0;
        eway  = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (en[w] && (st[w] == '0)) begin
                empty = 1'b1;
                eway  = WW'(w);
            end
        end

        // Minimum-stamp tree; ties go to the lower way. Unused ways sit at the top.
        for (int i = 0; i < P; i++) begin
            nst[P-1+i] = (i < MAX_WAYS && en[i]) ? st[i] : '1;
            nid[P-1+i] = WW'(i);
        end
        for (int i = P - 2; i >= 0; i--) begin
            if (nst[2*i+1] <= nst[2*i+2]) begin
                nst[i] = nst[2*i+1];
                nid[i] = nid[2*i+1];
            end else begin
                nst[i] = nst[2*i+2];
                nid[i] = nid[2*i+2];
            end
        end

        o_res.hit   = hit;
        o_res.fill  = !hit && empty;
        o_res.evict = !hit && !empty;
        if (hit) begin
            o_way = hway;
        end else if (empty) begin
            o_way = eway;
        end else begin
            o_way = nid[0];
        end
    end

endmodule

FILE: rtl/core/lru_set_assoc_cache_lookup_top.sv
// An accepted word's set row is read from the stamp and tag memories into their read
// registers; in the lookup state its result word goes to the output register, and no new
// word is taken until then. Each access does one set read and one set write-back of the
// stamp and tag memories, and a modify's second lookup is resolved in the same pass.
// A full output register stalls the write-back.
// Reset (synchronous, active low) restores the configuration, clears the clock,
// the counters and the per-set valid bits; no clearing pass is needed.
module lru_set_assoc_cache_lookup_top #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Access channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lru_sac_pkg::OP_W-1:0]       i_operation,
    input  logic [lru_sac_pkg::ADDR_W-1:0]     i_address,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [lru_sac_pkg::OUT_W-1:0]      o_outcome,
    output logic                               o_second_hit,
    output logic [lru_sac_pkg::STAMP_W-1:0]    o_hits_total,
    output logic [lru_sac_pkg::STAMP_W-1:0]    o_misses_total,
    output logic [lru_sac_pkg::STAMP_W-1:0]    o_evictions_total,
    output logic                               o_clock_saturated,
    // Configuration channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lru_sac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lru_sac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW    = lru_sac_pkg::STAMP_W;
    localparam int TW    = lru_sac_pkg::TAG_W;
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW    = $clog2(MAX_WAYS + 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_LOOKUP = 1'b1;

    logic                    r_state, n_state;
    logic [2:0]              r_cfg_sbits;
    logic [5:0]              r_cfg_obits;
    logic [3:0]              r_cfg_ways;
    logic [SW-1:0]           r_clock;
    logic [SW-1:0]           r_hits, n_hits;
    logic [SW-1:0]           r_misses, n_misses;
    logic [SW-1:0]           r_evicts, n_evicts;
    logic [NSETS-1:0]        r_row_vld;
    logic [MAX_SET_BITS-1:0] r_set;
    logic [TW-1:0]           r_tag;
    logic [lru_sac_pkg::OP_W-1:0] r_op;
    logic                    r_out_valid;
    logic [lru_sac_pkg::OUT_W-1:0] r_outcome;
    logic                    r_second_hit;
    logic                    r_out_sat;

    logic                    in_acc;
    logic                    done;
    logic [3:0]              sbits_eff;
    logic [CW-1:0]           ways_eff;
    logic [MAX_SET_BITS-1:0] set_c;
    logic [TW-1:0]           tag_c;
    logic [6:0]              tshift;
    logic [TW-1:0]           shifted;
    logic [MAX_SET_BITS-1:0] set_mask;

    logic [MAX_WAYS*SW-1:0]  stamp_rd;
    logic [MAX_WAYS*SW-1:0]  stamp_row;
    logic [MAX_WAYS*TW-1:0]  tag_rd;
    logic [MAX_WAYS*SW-1:0]  n_stamp_row;
    logic [MAX_WAYS*TW-1:0]  n_tag_row;
    lru_sac_pkg::t_pick      pick;
    logic [WW-1:0]           pick_way;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign done        = (r_state == S_LOOKUP) && (!r_out_valid || i_out_ready);

    // Effective set-bit and way counts after clamping.
    always_comb begin
        if (32'(r_cfg_sbits) > MAX_SET_BITS) begin
            sbits_eff = 4'(MAX_SET_BITS);
        end else begin
            sbits_eff = {1'b0, r_cfg_sbits};
        end
        if (r_cfg_ways == '0) begin
            ways_eff = CW'(1);
        end else if (32'(r_cfg_ways) > MAX_WAYS) begin
            ways_eff = CW'(MAX_WAYS);
        end else begin
            ways_eff = CW'(r_cfg_ways);
        end
    end

    // Address split into set index and tag.
    always_comb begin
        shifted  = i_address >> r_cfg_obits;
        set_mask = ~({MAX_SET_BITS{1'b1}} << sbits_eff);
        set_c    = shifted[MAX_SET_BITS-1:0] & set_mask;
        tshift   = {1'b0, r_cfg_obits} + {3'b000, sbits_eff};
        tag_c    = (tshift >= 7'd64) ? '0 : (i_address >> tshift);
    end

    // Stamp and tag memories, one row per set.
    lru_sac_ram #(.WIDTH(MAX_WAYS*SW), .DEPTH(NSETS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (done),
        .i_waddr (r_set),
        .i_wdata (n_stamp_row),
        .i_re    (in_acc),
        .i_raddr (set_c),
        .o_rdata (stamp_rd)
    );

    lru_sac_ram #(.WIDTH(MAX_WAYS*TW), .DEPTH(NSETS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (done),
        .i_waddr (r_set),
        .i_wdata (n_tag_row),
        .i_re    (in_acc),
        .i_raddr (set_c),
        .o_rdata (tag_rd)
    );

    // A set never written since reset reads as all lines invalid.
    assign stamp_row = r_row_vld[r_set] ? stamp_rd : '0;

    lru_sac_pick #(.MAX_WAYS(MAX_WAYS)) u_pick (
        .i_stamps (stamp_row),
        .i_tags   (tag_rd),
        .i_tag    (r_tag),
        .i_ways   (ways_eff),
        .o_res    (pick),
        .o_way    (pick_way)
    );

    // Write-back rows: the chosen line takes the current stamp and the tag.
    always_comb begin
        n_stamp_row = stamp_row;
        n_tag_row   = tag_rd;
        n_stamp_row[pick_way*SW +: SW] = r_clock;
        n_tag_row[pick_way*TW +: TW]   = r_tag;
    end

    // Counter updates; a modify's second lookup always hits the line just used.
    always_comb begin
        n_hits   = pick.hit ? lru_sac_pkg::sat_inc(r_hits) : r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        if (r_op == lru_sac_pkg::OP_MODIFY) begin
            n_hits = lru_sac_pkg::sat_inc(n_hits);
        end
        if (!pick.hit) begin
            n_misses = lru_sac_pkg::sat_inc(r_misses);
        end
        if (pick.evict) begin
            n_evicts = lru_sac_pkg::sat_inc(r_evicts);
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_sbits <= lru_sac_pkg::RST_SET_BITS;
            r_cfg_obits <= lru_sac_pkg::RST_OFFSET_BITS;
            r_cfg_ways  <= lru_sac_pkg::RST_WAYS;
            r_clock     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    lru_sac_pkg::CFG_SET_BITS:    r_cfg_sbits <= i_cfg_data[2:0];
                    lru_sac_pkg::CFG_OFFSET_BITS: r_cfg_obits <= i_cfg_data;
                    lru_sac_pkg::CFG_WAYS:        r_cfg_ways  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_clock <= lru_sac_pkg::sat_inc(r_clock);
            end
            if (done) begin
                r_hits           <= n_hits;
                r_misses         <= n_misses;
                r_evicts         <= n_evicts;
                r_row_vld[r_set] <= 1'b1;
                r_out_valid      <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Access and result payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set <= set_c;
            r_tag <= tag_c;
            r_op  <= i_operation;
        end
        if (done) begin
            if (pick.hit) begin
                r_outcome <= lru_sac_pkg::OUT_HIT;
            end else if (pick.fill) begin
                r_outcome <= lru_sac_pkg::OUT_FILL;
            end else begin
                r_outcome <= lru_sac_pkg::OUT_EVICT;
            end
            r_second_hit <= (r_op == lru_sac_pkg::OP_MODIFY);
            r_out_sat    <= (r_clock == lru_sac_pkg::SAT32);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_outcome         = r_outcome;
    assign o_second_hit      = r_second_hit;
    assign o_hits_total      = r_hits;
    assign o_misses_total    = r_misses;
    assign o_evictions_total = r_evicts;
    assign o_clock_saturated = r_out_sat;

endmodule

FILE: rtl/core/lru_sac_chk.sv
module lru_sac_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [lru_sac_pkg::STAMP_W-1:0] o_hits_total,
    input logic [lru_sac_pkg::STAMP_W-1:0] o_misses_total,
    input logic [lru_sac_pkg::STAMP_W-1:0] o_evictions_total
);

    // A waiting result word stays valid and keeps its hit total.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hits_total))
        else $error("result word changed while stalled");

    // An access occupies the lookup pass for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("access accepted during a lookup pass");

    // The hit total never goes down outside reset.
    a_hits_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_hits_total >= $past(o_hits_total))
        else $error("hit total decreased");

    // Every eviction is also a miss.
    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evictions_total <= o_misses_total)
        else $error("eviction total exceeds miss total");

endmodule

bind lru_set_assoc_cache_lookup_top lru_sac_chk u_lru_sac_chk (.*);
